// ===== rtl/core/rsw_pkg.sv =====
// Package for the receiver sliding window ack core.
// Holds the request and result structs, per-peer entry layout, controller
// states and command struct. No dependencies.
`default_nettype none
package rsw_pkg;

	localparam int PEERS     = 32;
	localparam int SEQ_MAX   = 512;
	localparam int WIN_BITS  = 64;              // received bits kept beyond next_expected
	localparam int OFS_W     = $clog2(WIN_BITS);
	localparam int SHIFT_W   = OFS_W + 1;
	localparam int GRP_W     = 8;
	localparam int GROUPS    = WIN_BITS / GRP_W;
	localparam int GSEL_W    = $clog2(GROUPS);
	localparam int GBIT_W    = $clog2(GRP_W);

	localparam logic [6:0] WIN_RESET = 7'd8;
	localparam logic [6:0] WIN_MIN   = 7'd1;
	localparam logic [6:0] WIN_MAX   = 7'd64;
	localparam logic [9:0] NX_RESET  = 10'd1;
	localparam logic [9:0] BOUND_MAX = 10'd1023;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [1:0] VERDICT_START   = 2'd0;
	localparam logic [1:0] VERDICT_ACK     = 2'd1;
	localparam logic [1:0] VERDICT_DISCARD = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [4:0]  peer_index;
		logic [9:0]  seq_number;
		logic [15:0] chunk_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [9:0]  ack_number;
		logic [4:0]  ack_peer;
		logic [15:0] ack_chunk;
	} out_item_t;

	// rx_bits[k] marks sequence next_expected + k as received
	typedef struct packed {
		logic [9:0]          next_expected;
		logic [9:0]          upper_bound;
		logic [WIN_BITS-1:0] rx_bits;
	} peer_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CLASS,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic read;
		logic eval;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsw_ctrl.sv =====
// Controller for the receiver sliding window ack core: sequences one request
// through read, classify and scan/commit. Depends on rsw_pkg.
`default_nettype none
module rsw_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output rsw_pkg::cmd_t      cmd,
	output logic               busy
);

	rsw_pkg::state_t state_q;
	rsw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			rsw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rsw_pkg::ST_READ;
				end
			end
			rsw_pkg::ST_READ: begin
				cmd.read = 1'b1;
				state_d  = rsw_pkg::ST_CLASS;
			end
			rsw_pkg::ST_CLASS: begin
				cmd.eval = 1'b1;
				state_d  = rsw_pkg::ST_SCAN;
			end
			rsw_pkg::ST_SCAN: begin
				cmd.commit = 1'b1;
				state_d    = rsw_pkg::ST_IDLE;
			end
			default: begin
				state_d = rsw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/rsw_datapath.sv =====
// Datapath for the receiver sliding window ack core: request latch, per-peer
// window memory with valid bits, classification, run scan and result register.
// Depends on rsw_pkg.
`default_nettype none
module rsw_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rsw_pkg::cmd_t      cmd,
	input  wire rsw_pkg::in_item_t  item,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_wdata,
	output logic                    done,
	output rsw_pkg::out_item_t      result
);

	typedef enum logic [2:0] {
		ACT_START,
		ACT_DISCARD,
		ACT_ACK_ONLY,
		ACT_MARK_OOO,
		ACT_MARK_EXP
	} act_t;

	localparam int RUN_LEN = rsw_pkg::WIN_BITS - 1;

	logic [6:0]           win_q;
	logic [6:0]           win_eff;
	rsw_pkg::in_item_t    req_q;

	rsw_pkg::peer_entry_t mem [rsw_pkg::PEERS];
	logic [rsw_pkg::PEERS-1:0] valid_q;
	rsw_pkg::peer_entry_t rd_q;
	logic                 rd_vld_q;

	rsw_pkg::peer_entry_t cur;
	logic                 peer_ok;
	logic [9:0]           lim;
	logic [9:0]           ofs_full;
	logic [9:0]           run_full;
	logic [rsw_pkg::WIN_BITS-1:0] run_m;
	logic [rsw_pkg::GROUPS-1:0]   grp_full;
	act_t                 act;

	act_t                         act_s2;
	rsw_pkg::peer_entry_t         ent_s2;
	logic [rsw_pkg::OFS_W-1:0]    ofs_s2;
	logic [rsw_pkg::WIN_BITS-1:0] run_s2;
	logic [rsw_pkg::GROUPS-1:0]   gfull_s2;

	logic [rsw_pkg::GSEL_W-1:0]   gsel;
	logic [rsw_pkg::GRP_W-1:0]    grp;
	logic [rsw_pkg::GBIT_W-1:0]   gcnt;
	logic [rsw_pkg::OFS_W-1:0]    run_t;
	logic [rsw_pkg::SHIFT_W-1:0]  shift;
	logic [rsw_pkg::WIN_BITS-1:0] marked;
	logic [10:0]                  nb_full;
	logic [9:0]                   nb;
	logic [9:0]                   ack_exp;

	logic                 mem_we;
	rsw_pkg::peer_entry_t mem_wdata;
	rsw_pkg::out_item_t   res_d;

	// window size register and its clamped form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= rsw_pkg::WIN_RESET;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (win_q == 7'd0) begin
			win_eff = rsw_pkg::WIN_MIN;
		end else if (win_q > rsw_pkg::WIN_MAX) begin
			win_eff = rsw_pkg::WIN_MAX;
		end else begin
			win_eff = win_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= item;
		end
	end

	// per-peer window memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[req_q.peer_index] <= mem_wdata;
		end
		if (cmd.read) begin
			rd_q <= mem[req_q.peer_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[req_q.peer_index] <= 1'b1;
			end
			if (cmd.read) begin
				rd_vld_q <= valid_q[req_q.peer_index];
			end
		end
	end

	// classify the request against the peer's window
	always_comb begin
		if (rd_vld_q) begin
			cur = rd_q;
		end else begin
			cur.next_expected = rsw_pkg::NX_RESET;
			cur.upper_bound   = {3'd0, rsw_pkg::WIN_RESET};
			cur.rx_bits       = '0;
		end
		peer_ok = int'(req_q.peer_index) < rsw_pkg::PEERS;
		if (!peer_ok) begin
			act = ACT_DISCARD;
		end else if (req_q.operation == rsw_pkg::OP_START) begin
			act = ACT_START;
		end else if (req_q.seq_number < cur.next_expected) begin
			act = ACT_DISCARD;
		end else if (req_q.seq_number > cur.upper_bound ||
		             req_q.seq_number > 10'(rsw_pkg::SEQ_MAX)) begin
			act = ACT_ACK_ONLY;
		end else if (req_q.seq_number != cur.next_expected) begin
			act = ACT_MARK_OOO;
		end else begin
			act = ACT_MARK_EXP;
		end

		lim      = (cur.upper_bound < 10'(rsw_pkg::SEQ_MAX)) ?
		           cur.upper_bound : 10'(rsw_pkg::SEQ_MAX);
		ofs_full = req_q.seq_number - cur.next_expected;
		run_full = lim - cur.next_expected;

		// run candidates above the expected slot, cut at the scan limit
		run_m = '0;
		for (int k = 0; k < RUN_LEN; k++) begin
			run_m[k] = cur.rx_bits[k+1] && (10'(k) < run_full);
		end
		for (int g = 0; g < rsw_pkg::GROUPS; g++) begin
			grp_full[g] = &run_m[g*rsw_pkg::GRP_W +: rsw_pkg::GRP_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			act_s2   <= act;
			ent_s2   <= cur;
			ofs_s2   <= ofs_full[rsw_pkg::OFS_W-1:0];
			run_s2   <= run_m;
			gfull_s2 <= grp_full;
		end
	end

	// count the received run, slide and build the result
	always_comb begin
		gsel = '0;
		for (int g = rsw_pkg::GROUPS - 1; g >= 0; g--) begin
			if (!gfull_s2[g]) begin
				gsel = rsw_pkg::GSEL_W'(g);
			end
		end
		grp  = run_s2[gsel*rsw_pkg::GRP_W +: rsw_pkg::GRP_W];
		gcnt = '0;
		for (int j = rsw_pkg::GRP_W - 1; j >= 0; j--) begin
			if (!grp[j]) begin
				gcnt = rsw_pkg::GBIT_W'(j);
			end
		end
		run_t   = {gsel, gcnt};
		shift   = {1'b0, run_t} + rsw_pkg::SHIFT_W'(1);
		marked  = ent_s2.rx_bits | (rsw_pkg::WIN_BITS'(1) << ofs_s2);
		ack_exp = ent_s2.next_expected + 10'(run_t);
		nb_full = {1'b0, ack_exp} + {4'd0, win_eff};
		nb      = (nb_full > {1'b0, rsw_pkg::BOUND_MAX}) ? rsw_pkg::BOUND_MAX
		                                                 : nb_full[9:0];

		mem_we           = 1'b0;
		mem_wdata        = ent_s2;
		res_d.verdict    = rsw_pkg::VERDICT_DISCARD;
		res_d.ack_number = '0;
		res_d.ack_peer   = req_q.peer_index;
		res_d.ack_chunk  = req_q.chunk_id;
		unique case (act_s2)
			ACT_START: begin
				mem_we                  = cmd.commit;
				mem_wdata.next_expected = rsw_pkg::NX_RESET;
				mem_wdata.upper_bound   = {3'd0, win_eff};
				mem_wdata.rx_bits       = '0;
				res_d.verdict           = rsw_pkg::VERDICT_START;
			end
			ACT_DISCARD: begin
				res_d.verdict = rsw_pkg::VERDICT_DISCARD;
			end
			ACT_ACK_ONLY: begin
				res_d.verdict    = rsw_pkg::VERDICT_ACK;
				res_d.ack_number = ent_s2.next_expected - 10'd1;
			end
			ACT_MARK_OOO: begin
				mem_we            = cmd.commit;
				mem_wdata.rx_bits = marked;
				res_d.verdict     = rsw_pkg::VERDICT_ACK;
				res_d.ack_number  = ent_s2.next_expected - 10'd1;
			end
			ACT_MARK_EXP: begin
				mem_we                  = cmd.commit;
				mem_wdata.next_expected = ack_exp + 10'd1;
				mem_wdata.upper_bound   = nb;
				mem_wdata.rx_bits       = marked >> shift;
				res_d.verdict           = rsw_pkg::VERDICT_ACK;
				res_d.ack_number        = ack_exp;
			end
			default: begin
				res_d.verdict = rsw_pkg::VERDICT_DISCARD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result <= res_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/receiver_sliding_window_ack_core.sv =====
// Top level of the receiver sliding window ack core.
// Instantiates rsw_ctrl and rsw_datapath; depends on rsw_pkg.
//
//  channel   ports                      handshake
//  request   start, busy, item          taken when start && !busy
//  result    done, result               one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata          write when cfg_we, window_size
//
// Each request runs through a memory read, a classify stage and a scan/commit
// stage before the next one is accepted; the result strobe comes in the cycle
// the next request can be taken.
// The run scan is split over the classify and commit stages in 8-bit groups.
// Reset clears all peer windows at once through per-peer valid bits.
// The result side cannot stall; done is high for exactly one cycle.
`default_nettype none
module receiver_sliding_window_ack_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire rsw_pkg::in_item_t  item,
	output logic                    done,
	output rsw_pkg::out_item_t      result,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_wdata
);

	rsw_pkg::cmd_t cmd;

	rsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy)
	);

	rsw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

// ===== rtl/core/rsw_checker.sv =====
// Port-level checker for the receiver sliding window ack core, bound to the
// top level. Depends on rsw_pkg.
`default_nettype none
module rsw_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire rsw_pkg::in_item_t  item,
	input wire logic               done,
	input wire rsw_pkg::out_item_t result
);

	// every accepted request yields its result after the read, classify and scan/commit states
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result strobe missing after accepted request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_echo_peer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 (result.ack_peer == $past(item.peer_index, 4) &&
		                        result.ack_chunk == $past(item.chunk_id, 4) &&
		                        result.verdict != 2'd3))
		else $error("result does not match its request");

endmodule

bind receiver_sliding_window_ack_core rsw_checker u_rsw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);
`default_nettype wire
